>>> rtl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared constants, codes and offset helpers of the local binary pattern
// stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int RADIUS_DEF    = 3;
   localparam int NEIGHBORS_DEF = 5;

   localparam int MAX_HEIGHT    = 4096;
   localparam int TRIG_SCALE    = 10000;

   localparam int PIXEL_W        = 8;
   localparam int CODE_W         = 8;
   localparam int ROW_W          = 12;
   localparam int IMAGE_WIDTH_W  = 11;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [IMAGE_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [IMAGE_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } operation_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // cos and sin of 2*pi*k/n scaled by TRIG_SCALE, row n-1, column k
   localparam int COS_TAB [8][8] = '{
      '{10000,     0,     0,     0,      0,     0,     0,    0},
      '{10000, -10000,    0,     0,      0,     0,     0,    0},
      '{10000, -5000, -5000,     0,      0,     0,     0,    0},
      '{10000,     0, -10000,    0,      0,     0,     0,    0},
      '{10000,  3090, -8090, -8090,   3090,     0,     0,    0},
      '{10000,  5000, -5000, -10000, -5000,  5000,     0,    0},
      '{10000,  6235, -2225, -9010,  -9010, -2225,  6235,    0},
      '{10000,  7071,     0, -7071, -10000, -7071,     0, 7071}};

   localparam int SIN_TAB [8][8] = '{
      '{0,    0,     0,     0,     0,      0,      0,     0},
      '{0,    0,     0,     0,     0,      0,      0,     0},
      '{0, 8660, -8660,     0,     0,      0,      0,     0},
      '{0, 10000,    0, -10000,    0,      0,      0,     0},
      '{0, 9511,  5878, -5878, -9511,      0,      0,     0},
      '{0, 8660,  8660,     0, -8660,  -8660,      0,     0},
      '{0, 7818,  9749,  4339, -4339,  -9749,  -7818,     0},
      '{0, 7071, 10000,  7071,     0,  -7071, -10000, -7071}};

   // column offset of neighbor k, truncated toward zero
   function automatic int offset_dx(int n, int r, int k);
      return (r * COS_TAB[(n - 1) % 8][k % 8]) / TRIG_SCALE;
   endfunction

   // row offset of neighbor k, image rows grow downward
   function automatic int offset_dy(int n, int r, int k);
      return -((r * SIN_TAB[(n - 1) % 8][k % 8]) / TRIG_SCALE);
   endfunction

endpackage

`default_nettype wire

>>> rtl/lbps_ram.sv
// ----------------------------------------------------------------------------
// lbps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_ram #(
   parameter int WIDTH = 2 * lbps_pkg::RADIUS_DEF * lbps_pkg::PIXEL_W,
   parameter int DEPTH = lbps_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/local_binary_pattern_stream_core.sv
// ----------------------------------------------------------------------------
// local_binary_pattern_stream_core
// Streaming local binary pattern of a gray frame in raster order.
// ----------------------------------------------------------------------------
// Takes one request per clock, pixel or drain, and returns one code per
// clock, while rsp_stall stays low; each code passes through the stage 1
// register and the result register. The rate is set by the line store: one
// column word (2*RADIUS rows of a column) is read as a pixel request is taken
// and written back as stage 1 moves on, and a column is touched again only a
// full row later, so the read-modify-write never collides. A stall on the
// result side holds the request behind it after at most one further request.
// The line store has no clearing pass: contents from before the first frame
// never reach a code that is not a border code. Writing image_width or
// image_height restarts the frame and drops pending codes; widths are clamped
// to [2*RADIUS+1, MAX_WIDTH] and heights to [2*RADIUS+1, 4096].
// ----------------------------------------------------------------------------
`default_nettype none

module local_binary_pattern_stream_core #(
   parameter int MAX_WIDTH = lbps_pkg::MAX_WIDTH_DEF,
   parameter int RADIUS    = lbps_pkg::RADIUS_DEF,
   parameter int NEIGHBORS = lbps_pkg::NEIGHBORS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_operation,
   input  wire logic [lbps_pkg::PIXEL_W-1:0]          req_gray_pixel,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [lbps_pkg::CODE_W-1:0]           rsp_lbp_code,
   output logic                                       rsp_frame_end,

   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [lbps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [lbps_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic      [lbps_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                       csr_pready
);

   localparam int WIN    = 2 * RADIUS + 1;
   localparam int LINES  = 2 * RADIUS;
   localparam int PW     = lbps_pkg::PIXEL_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WC_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = lbps_pkg::ROW_W;
   localparam int HW     = lbps_pkg::IMAGE_HEIGHT_W;
   localparam int WW     = lbps_pkg::IMAGE_WIDTH_W;
   localparam int PEND_W = $clog2(MAX_WIDTH * lbps_pkg::MAX_HEIGHT + 1);
   localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;

   typedef logic [LINES-1:0][PW-1:0]         line_word_type;
   typedef logic [WIN-1:0][WIN-1:0][PW-1:0]  window_type;

   // configuration
   logic [WW-1:0] image_width_ff,  image_width_in;
   logic [HW-1:0] image_height_ff, image_height_in;
   logic          csr_write;
   logic [WC_W-1:0] wc;
   logic [HW-1:0]   hc;
   logic [PEND_W-1:0] delay_w;

   // input and output side positions and pending count
   logic [COL_W-1:0]  icol_ff, icol_in;
   logic [ROW_W-1:0]  irow_ff, irow_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [ROW_W-1:0]  orow_ff, orow_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [PEND_W-1:0] pend_plus;
   logic              icol_last, irow_last, ocol_last, orow_last;

   logic              accept;
   logic              s0_emit, s0_interior, s0_frame_end;

   // stage 1: line store data back
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_op_ff, s1_op_in;
   logic              s1_emit_ff, s1_emit_in;
   logic              s1_interior_ff, s1_interior_in;
   logic              s1_frame_end_ff, s1_frame_end_in;
   logic [PW-1:0]     s1_pix_ff, s1_pix_in;
   logic [SLOT_W-1:0] s1_slot_ff, s1_slot_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;
   logic              s1_move;
   logic              s1_pixel;

   window_type        win_ff, win_in, win_shift;
   line_word_type     ram_rd_word, ram_wr_word;
   logic [lbps_pkg::CODE_W-1:0] code;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lbps_pkg::CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic                        rsp_frame_end_ff, rsp_frame_end_in;
   logic                        out_free;

   logic              ram_wr_en, ram_rd_en;
   logic [COL_W-1:0]  ram_wr_addr, ram_rd_addr;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         case (lbps_pkg::csr_index_type'(csr_paddr[2]))
            lbps_pkg::REG_IMAGE_WIDTH:  image_width_in  = csr_pwdata[WW-1:0];
            lbps_pkg::REG_IMAGE_HEIGHT: image_height_in = csr_pwdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (lbps_pkg::csr_index_type'(csr_paddr[2]))
         lbps_pkg::REG_IMAGE_WIDTH:  csr_prdata = lbps_pkg::CSR_DATA_W'(image_width_ff);
         lbps_pkg::REG_IMAGE_HEIGHT: csr_prdata = lbps_pkg::CSR_DATA_W'(image_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // clamped frame size in use
   always_comb begin
      if (int'(image_width_ff) < WIN) begin
         wc = WC_W'(WIN);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         wc = WC_W'(MAX_WIDTH);
      end else begin
         wc = WC_W'(image_width_ff);
      end
      if (int'(image_height_ff) < WIN) begin
         hc = HW'(WIN);
      end else if (int'(image_height_ff) > lbps_pkg::MAX_HEIGHT) begin
         hc = HW'(lbps_pkg::MAX_HEIGHT);
      end else begin
         hc = image_height_ff;
      end
   end

   assign delay_w = PEND_W'(RADIUS * int'(wc) + RADIUS);

   // ------------------------------------------------------------------
   // stage 0: request accept, position counters
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_pixel  = (lbps_pkg::operation_type'(s1_op_ff) == lbps_pkg::OP_PIXEL);
   assign s1_move   = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign pend_plus = pend_ff + 1'b1;
   assign icol_last = (WC_W'(icol_ff) == wc - WC_W'(1));
   assign irow_last = (HW'(irow_ff) == hc - HW'(1));
   assign ocol_last = (WC_W'(ocol_ff) == wc - WC_W'(1));
   assign orow_last = (HW'(orow_ff) == hc - HW'(1));

   always_comb begin
      if (lbps_pkg::operation_type'(req_operation) == lbps_pkg::OP_PIXEL) begin
         s0_emit = (pend_plus > delay_w);
      end else begin
         s0_emit = (pend_ff != '0);
      end
      s0_interior = (int'(orow_ff) >= RADIUS) && (HW'(orow_ff) < hc - HW'(RADIUS)) &&
                    (int'(ocol_ff) >= RADIUS) && (WC_W'(ocol_ff) < wc - WC_W'(RADIUS));
      s0_frame_end = orow_last && ocol_last;
   end

   always_comb begin
      icol_in = icol_ff;
      irow_in = irow_ff;
      slot_in = slot_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      pend_in = pend_ff;
      if (csr_write) begin
         // restart of the frame
         icol_in = '0;
         irow_in = '0;
         slot_in = '0;
         ocol_in = '0;
         orow_in = '0;
         pend_in = '0;
      end else if (accept) begin
         if (lbps_pkg::operation_type'(req_operation) == lbps_pkg::OP_PIXEL) begin
            pend_in = s0_emit ? pend_ff : pend_plus;
            if (icol_last) begin
               icol_in = '0;
               if (irow_last) begin
                  irow_in = '0;
                  slot_in = '0;
               end else begin
                  irow_in = irow_ff + 1'b1;
                  slot_in = (int'(slot_ff) == LINES - 1) ? '0 : slot_ff + 1'b1;
               end
            end else begin
               icol_in = icol_ff + 1'b1;
            end
         end else if (s0_emit) begin
            pend_in = pend_ff - 1'b1;
         end
         if (s0_emit) begin
            if (ocol_last) begin
               ocol_in = '0;
               orow_in = orow_last ? '0 : orow_ff + 1'b1;
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_op_in        = s1_op_ff;
      s1_emit_in      = s1_emit_ff;
      s1_interior_in  = s1_interior_ff;
      s1_frame_end_in = s1_frame_end_ff;
      s1_pix_in       = s1_pix_ff;
      s1_slot_in      = s1_slot_ff;
      s1_col_in       = s1_col_ff;
      if (accept) begin
         s1_valid_in     = 1'b1;
         s1_op_in        = req_operation;
         s1_emit_in      = s0_emit;
         s1_interior_in  = s0_interior;
         s1_frame_end_in = s0_frame_end;
         s1_pix_in       = req_gray_pixel;
         s1_slot_in      = slot_ff;
         s1_col_in       = icol_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // line store: one word per column, one byte per buffered row
   // ------------------------------------------------------------------
   assign ram_rd_en   = accept &&
                        (lbps_pkg::operation_type'(req_operation) == lbps_pkg::OP_PIXEL);
   assign ram_rd_addr = icol_ff;
   assign ram_wr_en   = s1_move && s1_pixel;
   assign ram_wr_addr = s1_col_ff;

   lbps_ram #(
      .WIDTH (LINES * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_word)
   );

   // ------------------------------------------------------------------
   // stage 1: window shift, code, write back
   // ------------------------------------------------------------------
   always_comb begin
      int idx;
      idx = 0;
      for (int c = 0; c < WIN - 1; c++) begin
         win_shift[c] = win_ff[c + 1];
      end
      // byte of slot s holds the row that is LINES rows old at slot s
      for (int i = 0; i < LINES; i++) begin
         idx = int'(s1_slot_ff) + i;
         if (idx >= LINES) begin
            idx = idx - LINES;
         end
         win_shift[WIN - 1][i] = ram_rd_word[idx[SLOT_W-1:0]];
      end
      win_shift[WIN - 1][WIN - 1] = s1_pix_ff;
      for (int s = 0; s < LINES; s++) begin
         ram_wr_word[s] = (s == int'(s1_slot_ff)) ? s1_pix_ff : ram_rd_word[s];
      end
   end

   always_comb begin
      int cx;
      int cy;
      cx   = 0;
      cy   = 0;
      code = '0;
      for (int k = 0; k < NEIGHBORS; k++) begin
         cx = RADIUS + lbps_pkg::offset_dx(NEIGHBORS, RADIUS, k);
         cy = RADIUS + lbps_pkg::offset_dy(NEIGHBORS, RADIUS, k);
         code[k] = (win_shift[cx][cy] >= win_shift[RADIUS][RADIUS]);
      end
   end

   always_comb begin
      if (csr_write) begin
         win_in = '0;
      end else if (s1_move && s1_pixel) begin
         win_in = win_shift;
      end else begin
         win_in = win_ff;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (s1_move && s1_emit_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_code_in      = (s1_pixel && s1_interior_ff) ? code : '0;
         rsp_frame_end_in = s1_frame_end_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lbp_code  = rsp_code_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= lbps_pkg::WIDTH_RESET;
         image_height_ff <= lbps_pkg::HEIGHT_RESET;
         icol_ff         <= '0;
         irow_ff         <= '0;
         slot_ff         <= '0;
         ocol_ff         <= '0;
         orow_ff         <= '0;
         pend_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         win_ff          <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         icol_ff         <= icol_in;
         irow_ff         <= irow_in;
         slot_ff         <= slot_in;
         ocol_ff         <= ocol_in;
         orow_ff         <= orow_in;
         pend_ff         <= pend_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         win_ff          <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff         <= s1_op_in;
      s1_emit_ff       <= s1_emit_in;
      s1_interior_ff   <= s1_interior_in;
      s1_frame_end_ff  <= s1_frame_end_in;
      s1_pix_ff        <= s1_pix_in;
      s1_slot_ff       <= s1_slot_in;
      s1_col_ff        <= s1_col_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_no_same_column: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("line store read and write hit the same column");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= delay_w)
      else $error("pending count beyond the code delay");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WC_W'(icol_ff) < wc)
      else $error("input column outside the row");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && s0_emit && s0_frame_end |=> ocol_ff == '0 && orow_ff == '0)
      else $error("output position did not wrap after the last code");

endmodule

`default_nettype wire
